>>> src/nnis_pkg.sv
// ----------------------------------------------------------------------------
// nnis_pkg
// Types, constants and the shared division step of the nearest-neighbour
// image scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package nnis_pkg;

  localparam int COORD_W    = 8;   // column / row of a transaction
  localparam int SIZE_W     = 9;   // size registers
  localparam int PIXEL_W    = 24;  // packed pixel on the ports
  localparam int PROD_W     = 17;  // coordinate * size
  localparam int QUO_W      = 9;   // source coordinate from the divider
  localparam int QIDX_W     = $clog2(QUO_W);
  localparam int DIV_STEPS  = QUO_W;
  localparam int CFG_ADDR_W = 2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIXEL_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    logic               out_of_range;
  } out_item_t;

  // Sideband that travels with every transaction down the pipe
  typedef struct packed {
    logic               rd;    // read transaction
    logic               wr;    // write inside the source frame
    logic               oor;   // transaction outside the destination frame
    logic               zsrc;  // source size of zero
    logic [COORD_W-1:0] wcol;
    logic [COORD_W-1:0] wrow;
    logic [PIXEL_W-1:0] wpix;
  } meta_t;

  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
  } lane_t;

  // One restoring step: settles quotient bit k
  function automatic lane_t div_step(lane_t l, logic [SIZE_W-1:0] d,
                                     logic [QIDX_W-1:0] k);
    lane_t             r;
    logic [PROD_W-1:0] dsh;
    r   = l;
    dsh = PROD_W'(d) << k;
    if (l.rem >= dsh) begin
      r.rem    = l.rem - dsh;
      r.quo[k] = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/nnis_front.sv
// ----------------------------------------------------------------------------
// nnis_front
// Entry stage: decodes the transaction, checks bounds and forms the
// coordinate * size products for the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_front (
  input  logic                            clk,
  input  logic                            load,
  input  nnis_pkg::in_item_t              in_data,
  input  logic [nnis_pkg::SIZE_W-1:0]     src_w,
  input  logic [nnis_pkg::SIZE_W-1:0]     src_h,
  input  logic [nnis_pkg::SIZE_W-1:0]     dst_w,
  input  logic [nnis_pkg::SIZE_W-1:0]     dst_h,
  output nnis_pkg::meta_t                 meta_r,
  output nnis_pkg::lane_t                 lane_x_r,
  output nnis_pkg::lane_t                 lane_y_r
);
  import nnis_pkg::*;

  meta_t             meta_nxt;
  lane_t             lane_x_nxt;
  lane_t             lane_y_nxt;
  logic [SIZE_W-1:0] col_ext;
  logic [SIZE_W-1:0] row_ext;

  always_comb begin
    col_ext       = SIZE_W'(in_data.col);
    row_ext       = SIZE_W'(in_data.row);
    meta_nxt.rd   = (in_data.cmd == CMD_READ);
    meta_nxt.wr   = (in_data.cmd == CMD_WRITE) && (col_ext < src_w) && (row_ext < src_h);
    meta_nxt.oor  = (col_ext >= dst_w) || (row_ext >= dst_h);
    meta_nxt.zsrc = (src_w == '0) || (src_h == '0);
    meta_nxt.wcol = in_data.col;
    meta_nxt.wrow = in_data.row;
    meta_nxt.wpix = in_data.pixel_in;
    lane_x_nxt.rem = PROD_W'(in_data.col) * PROD_W'(src_w);
    lane_x_nxt.quo = '0;
    lane_y_nxt.rem = PROD_W'(in_data.row) * PROD_W'(src_h);
    lane_y_nxt.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      meta_r   <= meta_nxt;
      lane_x_r <= lane_x_nxt;
      lane_y_r <= lane_y_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/nnis_div.sv
// ----------------------------------------------------------------------------
// nnis_div
// Pipelined restoring divider, one quotient bit per stage, column and row
// lanes side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_div (
  input  logic                              clk,
  input  logic [nnis_pkg::DIV_STEPS-1:0]    load,
  input  nnis_pkg::meta_t                   meta_in,
  input  nnis_pkg::lane_t                   lane_x_in,
  input  nnis_pkg::lane_t                   lane_y_in,
  input  logic [nnis_pkg::SIZE_W-1:0]       dst_w,
  input  logic [nnis_pkg::SIZE_W-1:0]       dst_h,
  output nnis_pkg::meta_t                   meta_out,
  output logic [nnis_pkg::QUO_W-1:0]        sx,
  output logic [nnis_pkg::QUO_W-1:0]        sy
);
  import nnis_pkg::*;

  meta_t meta_r [DIV_STEPS];
  lane_t lx_r   [DIV_STEPS];
  lane_t ly_r   [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_stage
    localparam logic [QIDX_W-1:0] BIT = QIDX_W'(DIV_STEPS - 1 - s);
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (load[s]) begin
          meta_r[s] <= meta_in;
          lx_r[s]   <= div_step(lane_x_in, dst_w, BIT);
          ly_r[s]   <= div_step(lane_y_in, dst_h, BIT);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (load[s]) begin
          meta_r[s] <= meta_r[s-1];
          lx_r[s]   <= div_step(lx_r[s-1], dst_w, BIT);
          ly_r[s]   <= div_step(ly_r[s-1], dst_h, BIT);
        end
      end
    end
  end

  assign meta_out = meta_r[DIV_STEPS-1];
  assign sx       = lx_r[DIV_STEPS-1].quo;
  assign sy       = ly_r[DIV_STEPS-1].quo;

endmodule

`default_nettype wire

>>> src/nnis_frame_mem.sv
// ----------------------------------------------------------------------------
// nnis_frame_mem
// Frame store: writes land and reads are taken in the same stage, so
// transactions hit the store in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_frame_mem #(
  parameter int XW    = 8,
  parameter int YW    = 8,
  parameter int PIX_W = 24
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          in_vld,
  input  nnis_pkg::meta_t               meta_in,
  input  logic [nnis_pkg::QUO_W-1:0]    sx,
  input  logic [nnis_pkg::QUO_W-1:0]    sy,
  output logic [PIX_W-1:0]              rd_data_r,
  output nnis_pkg::meta_t               meta_r
);
  import nnis_pkg::*;

  localparam int DEPTH = 1 << (XW + YW);

  logic [PIX_W-1:0]   mem [DEPTH];
  logic [XW+YW-1:0]   wr_addr;
  logic [XW+YW-1:0]   rd_addr;

  // Columns/rows past the written area only arise for unwritten entries
  assign wr_addr = {meta_in.wrow[YW-1:0], meta_in.wcol[XW-1:0]};
  assign rd_addr = {sy[YW-1:0], sx[XW-1:0]};

  always_ff @(posedge clk) begin
    if (load) begin
      if (in_vld && meta_in.wr) begin
        mem[wr_addr] <= meta_in.wpix[PIX_W-1:0];
      end
      rd_data_r <= mem[rd_addr];
      meta_r    <= meta_in;
    end
  end

endmodule

`default_nettype wire

>>> src/nearest_neighbour_image_scaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbour_image_scaler
// Frame store with nearest-neighbour lookup from destination to source
// coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : valid/ready channel. cmd = write stores pixel_in at (col, row) of
//            the source frame (ignored outside src_width x src_height, no
//            result). cmd = read returns one out_* transaction with the
//            source pixel at (col*src_w/dst_w, row*src_h/dst_h).
//   out_*  : valid/ready channel, one transaction per read. A read outside
//            dst_width x dst_height returns zero with out_of_range set.
//   cfg_*  : write-only size registers, sampled on cfg_we; oversized values
//            act as the MAX parameter. Write only while the pipe is empty.
// Throughput: one transaction per cycle while out_ready does not stall the
//            pipe; set by the 9-stage divider pipe (one quotient bit per
//            stage) feeding a frame store with one write and one read port.
// Reset clears the pipe valid bits and sets all sizes to 256 (or the MAX
//   parameter). The frame store is not cleared: a read of a pixel never
//   written returns an unspecified value.
// Receiver stall: empty stages still close up, so in_ready drops only once
//   every stage holds a transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbour_image_scaler #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int CHANNELS   = 3
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  nnis_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output nnis_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [nnis_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [nnis_pkg::SIZE_W-1:0]        cfg_wdata
);
  import nnis_pkg::*;

  // Store columns/rows: writes never reach beyond 255 or beyond MAX
  localparam int W_LIM  = (MAX_WIDTH  < 256) ? MAX_WIDTH  : 256;
  localparam int H_LIM  = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
  localparam int XW     = $clog2(W_LIM);
  localparam int YW     = $clog2(H_LIM);
  // stored bytes, never more than the port carries
  localparam int PIX_W  = (8 * CHANNELS < PIXEL_W) ? 8 * CHANNELS : PIXEL_W;

  // Stage map: front, divider steps, store read, output register
  localparam int ST_FRONT = 0;
  localparam int ST_DIV0  = 1;
  localparam int ST_MEM   = DIV_STEPS + 1;
  localparam int ST_OUT   = DIV_STEPS + 2;
  localparam int NST      = DIV_STEPS + 3;

  // --------------------------------------------------------------------------
  // Size registers, held already clamped to the MAX parameters
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [SIZE_W-1:0] clamp_w, clamp_h;

  assign clamp_w = (32'(cfg_wdata) > MAX_WIDTH)  ? SIZE_W'(MAX_WIDTH)  : cfg_wdata;
  assign clamp_h = (32'(cfg_wdata) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= SIZE_W'(W_LIM);
      src_h_r <= SIZE_W'(H_LIM);
      dst_w_r <= SIZE_W'(W_LIM);
      dst_h_r <= SIZE_W'(H_LIM);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SRC_WIDTH:  src_w_r <= clamp_w;
        REG_SRC_HEIGHT: src_h_r <= clamp_h;
        REG_DST_WIDTH:  dst_w_r <= clamp_w;
        REG_DST_HEIGHT: dst_h_r <= clamp_h;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipe control: per-stage valid bits, a stage loads when it is empty or
  // the stage below moves on (bubbles collapse under a stall)
  // --------------------------------------------------------------------------
  logic [NST-1:0] vld_r, vld_nxt;
  logic [NST-1:0] load;
  meta_t          div_meta;

  always_comb begin
    load[NST-1] = !vld_r[NST-1] || out_ready;
    for (int s = NST - 2; s >= 0; s--) begin
      load[s] = !vld_r[s] || load[s+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    for (int s = 0; s < NST; s++) begin
      if (load[s]) begin
        if (s == ST_FRONT) begin
          vld_nxt[s] = in_valid;
        end else if (s == ST_MEM) begin
          // writes end at the store
          vld_nxt[s] = vld_r[s-1] && div_meta.rd;
        end else begin
          vld_nxt[s] = vld_r[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = load[ST_FRONT];
  assign out_valid = vld_r[ST_OUT];

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  meta_t              front_meta;
  lane_t              front_x, front_y;
  logic [QUO_W-1:0]   sx, sy;
  logic [PIX_W-1:0]   rd_data;
  meta_t              mem_meta;
  out_item_t          out_data_r, out_data_nxt;

  nnis_front u_front (
    .clk      (clk),
    .load     (load[ST_FRONT]),
    .in_data  (in_data),
    .src_w    (src_w_r),
    .src_h    (src_h_r),
    .dst_w    (dst_w_r),
    .dst_h    (dst_h_r),
    .meta_r   (front_meta),
    .lane_x_r (front_x),
    .lane_y_r (front_y)
  );

  nnis_div u_div (
    .clk       (clk),
    .load      (load[ST_DIV0 +: DIV_STEPS]),
    .meta_in   (front_meta),
    .lane_x_in (front_x),
    .lane_y_in (front_y),
    .dst_w     (dst_w_r),
    .dst_h     (dst_h_r),
    .meta_out  (div_meta),
    .sx        (sx),
    .sy        (sy)
  );

  nnis_frame_mem #(
    .XW    (XW),
    .YW    (YW),
    .PIX_W (PIX_W)
  ) u_mem (
    .clk       (clk),
    .load      (load[ST_MEM]),
    .in_vld    (vld_r[ST_MEM-1]),
    .meta_in   (div_meta),
    .sx        (sx),
    .sy        (sy),
    .rd_data_r (rd_data),
    .meta_r    (mem_meta)
  );

  // Out of range wins over an empty source; missing channels read as zero
  always_comb begin
    out_data_nxt.out_of_range = mem_meta.oor;
    if (mem_meta.oor || mem_meta.zsrc) begin
      out_data_nxt.pixel_out = '0;
    end else begin
      out_data_nxt.pixel_out = PIXEL_W'(rd_data);
    end
  end

  always_ff @(posedge clk) begin
    if (load[ST_OUT]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_data = out_data_r;

endmodule

`default_nettype wire

>>> src/nnis_checker.sv
// ----------------------------------------------------------------------------
// nnis_checker
// Port-level checks for the nearest-neighbour image scaler.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input nnis_pkg::out_item_t   out_data
);
  import nnis_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped under stall");

  // Reset empties the pipe
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // With no result pending every stage is free to take a transaction
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with output empty");

  // An out-of-range result never carries pixel data
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_of_range |-> out_data.pixel_out == '0)
    else $error("out-of-range result with non-zero pixel");

endmodule

bind nearest_neighbour_image_scaler nnis_checker u_nnis_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
